// ----- rtl/dfp_pkg.sv -----
// Package for the display frame parser: the queue item type, the parser phase,
// the register indexes and the protocol constants.
// No dependencies. Every module of the parser imports it.
package dfp_pkg;

  // Protocol bytes
  localparam logic [7:0] HDR_FIRST     = 8'h5A;
  localparam logic [7:0] HDR_SECOND    = 8'hA5;
  localparam logic [7:0] CMD_WRITE     = 8'h82;
  localparam logic [7:0] CMD_READ_RESP = 8'h83;
  localparam logic [7:0] MIN_VALUE_LEN = 8'd6;
  localparam logic [7:0] ERR_SAT       = 8'd255;

  // Reset values of the configuration registers
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0]  MIN_LEN_RESET = 8'd3;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Default sizes
  localparam int unsigned BUFFER_BYTES_DEF = 12;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  // One classified request as it travels from the front to the back
  typedef struct packed {
    logic       is_tick;  // idle tick rather than a received byte
    logic       is_hdr1;  // byte is the first header byte
    logic       is_hdr2;  // byte is the second header byte
    logic       is_rw;    // byte is a write or read-response command
    logic [7:0] data;
  } dfp_item_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_GOT_H = 4'b0010,
    PH_GOT_L = 4'b0100,
    PH_BODY  = 4'b1000
  } dfp_phase_e;

endpackage

// ----- rtl/dfp_front.sv -----
// Front end of the display frame parser: accepts requests and classifies them.
// Depends on dfp_pkg; feeds dfp_queue.
module dfp_front
  import dfp_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output dfp_item_t  q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.is_tick = cmd_i;
    q_item_o.is_hdr1 = (data_byte_i == HDR_FIRST);
    q_item_o.is_hdr2 = (data_byte_i == HDR_SECOND);
    q_item_o.is_rw   = (data_byte_i == CMD_WRITE) || (data_byte_i == CMD_READ_RESP);
    q_item_o.data    = data_byte_i;
  end

endmodule

// ----- rtl/dfp_queue.sv -----
// Short request queue between the front and back of the display frame parser.
// Depends on dfp_pkg for the item type.
module dfp_queue
  import dfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  dfp_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output dfp_item_t item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dfp_item_t         mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/dfp_back.sv -----
// Back end of the display frame parser: the frame state machine, frame store,
// counters, configuration registers and the output register.
// Depends on dfp_pkg; takes requests from dfp_queue.
module dfp_back
  import dfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // queue side
  input  logic                  q_empty_i,
  input  dfp_item_t             q_item_i,
  output logic                  q_pop_o,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // results
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_ok_o,
  output logic [15:0]           frame_address_o,
  output logic [15:0]           frame_value_o,
  output logic [7:0]            error_total_o,
  output logic [15:0]           frame_total_o
);

  localparam int unsigned IW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW   = $clog2(BUFFER_BYTES);
  localparam int unsigned CMPW = ((IW > 8) ? IW : 8) + 1;
  // frame positions, header and length first
  localparam int unsigned POS_CMD     = 3;
  localparam int unsigned POS_ADDR_HI = 4;
  localparam int unsigned POS_ADDR_LO = 5;
  localparam int unsigned POS_VAL_HI  = 7;
  localparam int unsigned POS_VAL_LO  = 8;

  dfp_phase_e      phase_q, phase_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     ticks_q, ticks_d;
  logic [7:0]      err_q, err_d;
  logic [15:0]     good_q, good_d;
  logic            cmd_rw_q, cmd_rw_d;
  logic [7:0]      store_q [BUFFER_BYTES];

  logic [15:0]     timeout_q;
  logic [7:0]      min_len_q, max_len_q;

  logic            out_valid_q;
  logic            ok_q;
  logic [15:0]     addr_q, val_q;

  logic            load;
  logic            store_we;
  logic            clear, err_inc, done, rw_now;
  logic            ok;
  logic [15:0]     addr, val;
  logic [7:0]      b_ahi, b_alo, b_vhi, b_vlo;

  // Advance whenever the output register is free or being taken
  assign load        = !out_valid_q || !out_stall_i;
  assign q_pop_o     = load && !q_empty_i;
  assign cfg_ready_o = 1'b1;

  // Bytes of the frame, taking the current byte where it has not landed yet
  assign b_ahi = (idx_q == IW'(POS_ADDR_HI)) ? q_item_i.data : store_q[POS_ADDR_HI];
  assign b_alo = (idx_q == IW'(POS_ADDR_LO)) ? q_item_i.data : store_q[POS_ADDR_LO];
  assign b_vhi = (idx_q == IW'(POS_VAL_HI))  ? q_item_i.data : store_q[POS_VAL_HI];
  assign b_vlo = (idx_q == IW'(POS_VAL_LO))  ? q_item_i.data : store_q[POS_VAL_LO];
  assign rw_now = (idx_q == IW'(POS_CMD)) ? q_item_i.is_rw : cmd_rw_q;
  assign done   = (CMPW'(idx_q) + CMPW'(1)) >= (CMPW'(len_q) + CMPW'(POS_CMD));

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    len_d    = len_q;
    ticks_d  = ticks_q;
    err_d    = err_q;
    good_d   = good_q;
    cmd_rw_d = cmd_rw_q;
    store_we = 1'b0;
    clear    = 1'b0;
    err_inc  = 1'b0;
    ok       = 1'b0;
    addr     = '0;
    val      = '0;
    if (q_item_i.is_tick) begin
      if (phase_q != PH_IDLE) begin
        if (ticks_q >= timeout_q) begin
          clear   = 1'b1;
          err_inc = 1'b1;
        end else begin
          ticks_d = ticks_q + 16'd1;
        end
      end
    end else begin
      ticks_d = '0;
      case (phase_q)
        PH_IDLE: begin
          if (q_item_i.is_hdr1) begin
            phase_d  = PH_GOT_H;
            idx_d    = IW'(1);
            store_we = 1'b1;
          end
        end
        PH_GOT_H: begin
          if (q_item_i.is_hdr2) begin
            phase_d  = PH_GOT_L;
            idx_d    = idx_q + IW'(1);
            store_we = 1'b1;
          end else if (q_item_i.is_hdr1) begin
            // restart the header on a repeated first byte
            idx_d    = IW'(1);
            store_we = 1'b1;
          end else begin
            clear = 1'b1;
          end
        end
        PH_GOT_L: begin
          len_d    = q_item_i.data;
          idx_d    = idx_q + IW'(1);
          store_we = 1'b1;
          if (q_item_i.data >= min_len_q && q_item_i.data <= max_len_q) begin
            phase_d = PH_BODY;
          end else begin
            clear   = 1'b1;
            err_inc = 1'b1;
          end
        end
        PH_BODY: begin
          if (idx_q >= IW'(BUFFER_BYTES)) begin
            // store full: drop the byte and the frame
            clear   = 1'b1;
            err_inc = 1'b1;
          end else begin
            store_we = 1'b1;
            idx_d    = idx_q + IW'(1);
            if (idx_q == IW'(POS_CMD)) begin
              cmd_rw_d = q_item_i.is_rw;
            end
            if (done) begin
              if (rw_now && len_q >= MIN_VALUE_LEN) begin
                ok     = 1'b1;
                addr   = {b_ahi, b_alo};
                val    = {b_vhi, b_vlo};
                good_d = good_q + 16'd1;
              end
              clear = 1'b1;
            end
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end
    if (clear) begin
      phase_d = PH_IDLE;
      idx_d   = '0;
      len_d   = '0;
      ticks_d = '0;
    end
    if (err_inc && err_q != ERR_SAT) begin
      err_d = err_q + 8'd1;
    end
  end

  // Frame store: write the current byte at its frame position
  always_ff @(posedge clk_i) begin
    if (q_pop_o && store_we) begin
      if (phase_q == PH_IDLE ||
          (phase_q == PH_GOT_H && q_item_i.is_hdr1 && !q_item_i.is_hdr2)) begin
        store_q[0] <= q_item_i.data;
      end else begin
        store_q[AW'(idx_q)] <= q_item_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_rw_q <= cmd_rw_d;
      ok_q     <= ok;
      addr_q   <= addr;
      val_q    <= val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      idx_q       <= '0;
      len_q       <= '0;
      ticks_q     <= '0;
      err_q       <= '0;
      good_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        len_q   <= len_d;
        ticks_q <= ticks_d;
        err_q   <= err_d;
        good_q  <= good_d;
      end
      if (load) begin
        out_valid_q <= !q_empty_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      min_len_q <= MIN_LEN_RESET;
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_MIN_LEN: min_len_q <= cfg_data_i[7:0];
        CFG_MAX_LEN: max_len_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_ok_o      = ok_q;
  assign frame_address_o = addr_q;
  assign frame_value_o   = val_q;
  assign error_total_o   = err_q;
  assign frame_total_o   = good_q;

endmodule

// ----- rtl/display_frame_parser.sv -----
// Top level of the display frame parser: front end, request queue and back end.
// Depends on dfp_pkg, dfp_front, dfp_queue and dfp_back.
//
// The parser takes one request per cycle while in_stall_o is low, a received
// serial byte (cmd_i low) or an idle tick (cmd_i high), and returns exactly
// one result per request, in order. It hunts for the header 5A A5, reads a
// length byte that must lie between min_length and max_length, then collects
// that many bytes. A frame whose command byte is 82 (write) or 83 (read
// response) and whose length is six or more yields frame_ok with the address
// from frame bytes four and five and the value from bytes seven and eight,
// big-endian; other frames give frame_ok low with zero address and value.
// Idle ticks in mid-frame count up to timeout_limit; the next one drops the
// frame. Timeouts, bad lengths and store overflow bump the saturating
// error_total; good frames with a value bump the wrapping frame_total. Both
// totals go out with every result. Sustained rate is one request per cycle
// while the output is not stalled; a request goes through the queue and the
// frame state machine and its result is loaded into the output register.
// The queue of QUEUE_DEPTH requests decouples input from output, so
// in_stall_o rises only once the queue has filled behind a stalled output.
// Configuration writes are always taken (cfg_ready_o is tied high); write
// them only while the parser has no request in flight.
module display_frame_parser
  import dfp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [7:0]            data_byte_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  frame_ok_o,
  output logic [15:0]           frame_address_o,
  output logic [15:0]           frame_value_o,
  output logic [7:0]            error_total_o,
  output logic [15:0]           frame_total_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic      q_full, q_empty, q_push, q_pop;
  dfp_item_t push_item, head_item;

  // Classify each request and hold it back while the queue is full
  dfp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  dfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  // Run the frame state machine on the queue head and drive the results
  dfp_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (head_item),
    .q_pop_o         (q_pop),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_ok_o      (frame_ok_o),
    .frame_address_o (frame_address_o),
    .frame_value_o   (frame_value_o),
    .error_total_o   (error_total_o),
    .frame_total_o   (frame_total_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for display_frame_parser: queued serial bytes and idle ticks go in,
// every result is checked against an in-bench frame parser. Depends on dfp_pkg and the RTL.
module testbench;
  import dfp_pkg::*;

  // Request kinds on cmd_i
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int STORE_BYTES   = BUFFER_BYTES_DEF;
  localparam int SETTLE_CYCLES = 12;    // pipeline plus queue, with margin
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] address;
    logic [15:0] value;
    logic [7:0]  errors;
    logic [15:0] frames;
  } frame_report_t;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  cmd_i       = REQ_BYTE;
  logic [7:0]            data_byte_i = 8'h00;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_TIMEOUT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        frame_ok_o;
  logic [15:0] frame_address_o;
  logic [15:0] frame_value_o;
  logic [7:0]  error_total_o;
  logic [15:0] frame_total_o;
  logic        cfg_ready_o;

  display_frame_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_ok_o      (frame_ok_o),
    .frame_address_o (frame_address_o),
    .frame_value_o   (frame_value_o),
    .error_total_o   (error_total_o),
    .frame_total_o   (frame_total_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  request_t      request_q[$];        // requests still to be offered
  frame_report_t frame_reports_q[$];  // results owed by the block, oldest first

  int   send_gap_pct  = 0;   // chance of the sender pausing between requests
  int   recv_gap_pct  = 0;   // chance of the receiver stalling a cycle
  int   hold_requests = 0;   // long hold-offs asked for
  int   hold_served   = 0;   // long hold-offs started
  int   hold_left     = 0;
  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  logic in_taken      = 1'b0;  // request on the bus was accepted at the last edge

  // Shadow of the configuration registers
  logic [15:0] cfg_timeout = TIMEOUT_RESET;
  logic [7:0]  cfg_min_len = MIN_LEN_RESET;
  logic [7:0]  cfg_max_len = MAX_LEN_RESET;

  // Shadow of the frame parser
  dfp_phase_e  ps_phase  = PH_IDLE;
  logic [3:0]  ps_index  = '0;
  logic [7:0]  ps_len    = '0;
  logic [15:0] ps_idle   = '0;
  logic [7:0]  ps_store [STORE_BYTES];
  logic [7:0]  ps_errors = '0;
  logic [15:0] ps_frames = '0;

  // ---------------------------------------------------------------------------
  // Frame parser: one request in, one report out
  // ---------------------------------------------------------------------------
  function automatic void clear_parser();
    ps_phase = PH_IDLE;
    ps_index = '0;
    ps_len   = '0;
    ps_idle  = '0;
  endfunction

  function automatic void bump_errors();
    if (ps_errors != ERR_SAT) ps_errors = ps_errors + 8'd1;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    if (int'(ps_index) < STORE_BYTES) ps_store[ps_index] = b;
    ps_index = ps_index + 4'd1;
  endfunction

  function automatic frame_report_t parse_request(input logic is_tick, input logic [7:0] b);
    frame_report_t rep;
    logic [7:0]    command;
    rep = '0;
    if (is_tick == REQ_TICK) begin
      // Ticks only matter mid-frame; the one past the limit drops the frame
      if (ps_phase != PH_IDLE) begin
        if (ps_idle >= cfg_timeout) begin
          clear_parser();
          bump_errors();
        end else begin
          ps_idle = ps_idle + 16'd1;
        end
      end
    end else begin
      ps_idle = '0;
      case (ps_phase)
        PH_IDLE: begin
          if (b == HDR_FIRST) begin
            ps_phase = PH_GOT_H;
            ps_index = '0;
            store_byte(b);
          end
        end
        PH_GOT_H: begin
          if (b == HDR_SECOND) begin
            ps_phase = PH_GOT_L;
            store_byte(b);
          end else if (b == HDR_FIRST) begin
            ps_index = '0;
            store_byte(b);
          end else begin
            clear_parser();
          end
        end
        PH_GOT_L: begin
          ps_len = b;
          store_byte(b);
          if (b >= cfg_min_len && b <= cfg_max_len) begin
            ps_phase = PH_BODY;
          end else begin
            clear_parser();
            bump_errors();
          end
        end
        PH_BODY: begin
          if (int'(ps_index) >= STORE_BYTES) begin
            // store full: the byte is lost and the frame dropped
            clear_parser();
            bump_errors();
          end else begin
            store_byte(b);
            if (int'(ps_index) >= 3 + int'(ps_len)) begin
              command = ps_store[3];
              if ((command == CMD_WRITE || command == CMD_READ_RESP) &&
                  ps_len >= MIN_VALUE_LEN) begin
                rep.ok      = 1'b1;
                rep.address = {ps_store[4], ps_store[5]};
                rep.value   = {ps_store[7], ps_store[8]};
                ps_frames   = ps_frames + 16'd1;
              end
              clear_parser();
            end
          end
        end
        default: clear_parser();
      endcase
    end
    rep.errors = ps_errors;
    rep.frames = ps_frames;
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic void push_req(input logic is_tick, input logic [7:0] b);
    request_t req;
    req.is_tick = is_tick;
    req.data    = b;
    request_q.push_back(req);
  endfunction

  // Queue the low n bytes of a vector, most significant first
  function automatic void push_seq(input logic [127:0] bytes, input int n);
    for (int k = n - 1; k >= 0; k--) push_req(REQ_BYTE, bytes[8*k +: 8]);
  endfunction

  function automatic void push_ticks(input int n);
    repeat (n) push_req(REQ_TICK, 8'($urandom_range(0, 255)));
  endfunction

  // Header, length, then the body cut short after 'cut' bytes; a length past
  // the store runs one byte into the overflow. Ticks fall between body bytes.
  function automatic int push_frame(input logic [7:0] len, input logic [7:0] command,
                                    input int cut);
    int body;
    int n;
    int burst;
    body = (len == 8'd0) ? 1 : ((len > 8'd10) ? 10 : int'(len));
    if (cut < body) body = cut;
    push_seq(128'({HDR_FIRST, HDR_SECOND, len}), 3);
    n = 3;
    for (int k = 0; k < body; k++) begin
      if ($urandom_range(0, 99) < 10) begin
        burst = $urandom_range(1, 5);
        push_ticks(burst);
        n += burst;
      end
      push_req(REQ_BYTE, (k == 0) ? command : 8'($urandom_range(0, 255)));
      n++;
    end
    return n;
  endfunction

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic queue_random_traffic(input int target);
    int          n;
    int          r;
    int          hi;
    logic [7:0]  len;
    logic [7:0]  command;
    n = 0;
    while (n < target) begin
      if (cfg_min_len <= cfg_max_len) begin
        hi = (cfg_max_len > 8'd12) ? 12 : int'(cfg_max_len);
        if (hi < int'(cfg_min_len)) hi = int'(cfg_min_len);
        r = $urandom_range(0, 99);
        if (r < 65)      len = 8'($urandom_range(hi, cfg_min_len));
        else if (r < 85) len = 8'($urandom_range(cfg_max_len, cfg_min_len));
        else             len = 8'($urandom_range(0, 255));
      end else begin
        len = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 40)      command = CMD_WRITE;
      else if (r < 80) command = CMD_READ_RESP;
      else             command = 8'($urandom_range(0, 255));

      r = $urandom_range(0, 99);
      if (r < 70) begin
        n += push_frame(len, command, 1000);
      end else if (r < 80) begin
        n += push_frame(len, command, $urandom_range(0, 4));
      end else if (r < 86) begin
        push_seq(128'({HDR_FIRST, 8'($urandom_range(0, 255))}), 2);
        n += 2;
      end else begin
        // line noise; mostly ignored, so it does not count
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) != 0) push_ticks(1);
          else push_req(REQ_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------
  // Wait until every request is in and every result is out, then let it settle
  task automatic drain();
    @(posedge clk_i);
    while (request_q.size() != 0 || in_valid_i || frame_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TIMEOUT: cfg_timeout = val;
      CFG_MIN_LEN: cfg_min_len = val[7:0];
      CFG_MAX_LEN: cfg_max_len = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reprogram the parser while idle and pick the idling for the next phase
  task automatic configure(input logic [15:0] timeout, input logic [7:0] min_len,
                           input logic [7:0] max_len, input int send_pct, input int recv_pct);
    drain();
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_MIN_LEN, {8'h00, min_len});
    write_reg(CFG_MAX_LEN, {8'h00, max_len});
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    // resume on a rising edge so new requests never race the driver
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next request at the falling edge, hold it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    request_t req;
    if (!in_valid_i || in_taken) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        req = request_q.pop_front();
        in_valid_i  <= 1'b1;
        cmd_i       <= req.is_tick;
        data_byte_i <= req.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk_i) begin : receiver
    logic stall_next;
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      stall_next = 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = HOLD_CYCLES - 1;
      stall_next  = 1'b1;
    end else begin
      stall_next = ($urandom_range(0, 99) < recv_gap_pct);
    end
    out_stall_i <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    frame_report_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o)
        frame_reports_q.push_back(parse_request(cmd_i, data_byte_i));
      if (out_valid_o && !out_stall_i) begin
        if (frame_reports_q.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %h",
                   $time, {frame_ok_o, frame_address_o, frame_value_o, error_total_o,
                           frame_total_o});
          mismatches++;
        end else begin
          want = frame_reports_q.pop_front();
          check_field("frame_ok", {15'd0, want.ok}, {15'd0, frame_ok_o});
          check_field("frame_address", want.address, frame_address_o);
          check_field("frame_value", want.value, frame_value_o);
          check_field("error_total", {8'd0, want.errors}, {8'd0, error_total_o});
          check_field("frame_total", want.frames, frame_total_o);
        end
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("display_frame_parser regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: sender idles more than a third of the time
    send_gap_pct = 34;
    recv_gap_pct = 58;
    push_ticks(1);                              // tick while hunting: ignored
    push_seq(128'h00, 1);                       // noise while hunting
    push_seq(128'h5AA50682FFFF01FFFF, 9);       // write, all-ones address and value
    push_seq(128'h5A5AA5058300000100, 9);       // repeated first header, length five
    push_seq(128'h5A00, 2);                     // bad second header byte, no error
    push_seq(128'h5AA502, 3);                   // length under the minimum

    // Short timeout: ticks up to the limit survive, one more drops the frame
    configure(16'd3, 8'd3, 8'd9, 34, 58);
    push_seq(128'h5AA50682, 4);
    push_ticks(3);
    push_seq(128'h1122013344, 5);
    push_seq(128'h5AA5, 2);
    push_ticks(4);
    push_seq(128'h5AA50610AABB01CCDD, 9);       // other command: consumed quietly
    queue_random_traffic(100);

    // Widest length range and zero timeout; roles of the two sides swap
    configure(16'd0, 8'd0, 8'd255, 58, 34);
    push_seq(128'h5AA50077, 4);                 // length zero takes one body byte
    push_seq(128'h5AA5FF821234015678ABCDEF00, 13);  // runs off the end of the store
    push_seq(128'h5A, 1);
    push_ticks(1);                              // times out at once
    queue_random_traffic(100);

    // Empty range: minimum above maximum rejects every length
    configure(16'd1, 8'd255, 8'd0, 58, 34);
    queue_random_traffic(30);

    // No idling, longest timeout, and one long hold-off so the queue backs up
    configure(16'hFFFF, 8'd6, 8'd6, 0, 0);
    queue_random_traffic(100);
    hold_requests = hold_requests + 1;

    drain();
    if (mismatches == 0) begin
      $display("display_frame_parser regression: pass");
    end else begin
      $display("display_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
